// ===== rtl/mtst_pkg.sv =====
// ----------------------------------------------------------------------------
// mtst_pkg
// Shared types, codes and helpers for the multitouch contact slot tracker.
// ----------------------------------------------------------------------------
package mtst_pkg;

    // Default number of contact slots
    localparam int SLOT_COUNT_DEF = 8;

    // Depth of the command queue between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // Reset value of the coordinate scale (1.0 in 8.8)
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // Item opcodes
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Touch report kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_MOVE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Result event kinds
    localparam logic [1:0] EVT_PRESSED  = 2'd0;
    localparam logic [1:0] EVT_MOVED    = 2'd1;
    localparam logic [1:0] EVT_RELEASED = 2'd2;

    // Input item
    typedef struct packed {
        logic        opcode;
        logic [1:0]  touch_kind;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [15:0] contact_id;
    } report_t;

    // Result item
    typedef struct packed {
        logic [2:0]  slot_index;
        logic [15:0] out_id;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic [1:0]  event_kind;
        logic        last;
    } result_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic        is_report;
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] id;
    } cmd_t;

    // Scale a 12-bit coordinate by an 8.8 factor, truncate and saturate
    function automatic logic [15:0] scale_coord(input logic [11:0] raw,
                                                input logic [15:0] scale);
        logic [27:0] prod;
        logic [19:0] shifted;
        begin
            prod    = 28'(raw) * 28'(scale);
            shifted = prod[27:8];
            if (shifted[19:16] != 4'd0)
            begin
                scale_coord = 16'hFFFF;
            end
            else
            begin
                scale_coord = shifted[15:0];
            end
        end
    endfunction

endpackage

// ===== rtl/mtst_front.sv =====
// ----------------------------------------------------------------------------
// mtst_front
// Accepts input items, scales coordinates and pushes commands to the queue.
// ----------------------------------------------------------------------------
module mtst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_stall,
    input  mtst_pkg::report_t report,
    input  logic              scale_valid,
    output logic              scale_ready,
    input  logic [15:0]       scale_data,
    output logic              push,
    output mtst_pkg::cmd_t    push_cmd,
    input  logic              queue_full
);
    import mtst_pkg::*;

    logic [15:0] scale_reg;

    // Hold the coordinate scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (scale_valid && scale_ready)
        begin
            scale_reg <= scale_data;
        end
    end

    assign scale_ready = 1'b1;

    // Stall while the queue is full
    assign report_stall = queue_full;
    assign push         = report_valid && !queue_full;

    // Classify the item and scale its coordinates
    always_comb
    begin
        push_cmd.is_report = (report.opcode == OP_REPORT);
        push_cmd.kind      = report.touch_kind;
        push_cmd.x         = scale_coord(report.raw_x, scale_reg);
        push_cmd.y         = scale_coord(report.raw_y, scale_reg);
        push_cmd.id        = report.contact_id;
    end

endmodule

// ===== rtl/mtst_queue.sv =====
// ----------------------------------------------------------------------------
// mtst_queue
// Short command queue decoupling the front from the slot engine.
// ----------------------------------------------------------------------------
module mtst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtst_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output mtst_pkg::cmd_t pop_cmd,
    output logic           not_empty
);
    import mtst_pkg::*;

    localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t             mem [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(CMD_QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];

    // Write the entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mtst_back.sv =====
// ----------------------------------------------------------------------------
// mtst_back
// Slot engine: applies a report, scans the slots emitting one result per
// occupied slot, then retires released slots and ages pressed ones.
// ----------------------------------------------------------------------------
module mtst_back #(
    parameter int SLOT_COUNT = mtst_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mtst_pkg::cmd_t    cmd,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output mtst_pkg::result_t result
);
    import mtst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        PH_EMPTY    = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_MOVING   = 2'd2,
        PH_RELEASED = 2'd3
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    phase_t           phase_reg   [SLOT_COUNT];
    logic [15:0]      contact_reg [SLOT_COUNT];
    logic [15:0]      x_reg       [SLOT_COUNT];
    logic [15:0]      y_reg       [SLOT_COUNT];
    phase_t           phase_next  [SLOT_COUNT];
    logic [15:0]      contact_next[SLOT_COUNT];
    logic [15:0]      x_next      [SLOT_COUNT];
    logic [15:0]      y_next      [SLOT_COUNT];
    logic             result_valid_reg;
    result_t          result_reg;

    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             cur_occupied;
    logic             more_after;
    logic             out_free;
    logic             emit;
    logic             advance;
    logic             scan_end;
    logic [IDX_W+2:0] idx_wide;
    logic [1:0]       cur_event;

    assign pop          = (state_reg == ST_IDLE) && cmd_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Find the slot holding the id and the lowest empty slot
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!hit_found && phase_reg[i] != PH_EMPTY && contact_reg[i] == cmd.id)
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!free_found && phase_reg[i] == PH_EMPTY)
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Look at the slot under the scan index
    always_comb
    begin
        cur_occupied = (phase_reg[idx_reg] != PH_EMPTY);
        more_after   = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (IDX_W'(i) > idx_reg && phase_reg[i] != PH_EMPTY)
            begin
                more_after = 1'b1;
            end
        end
        case (phase_reg[idx_reg])
            PH_PRESSED:  cur_event = EVT_PRESSED;
            PH_MOVING:   cur_event = EVT_MOVED;
            PH_RELEASED: cur_event = EVT_RELEASED;
            default:     cur_event = EVT_PRESSED;
        endcase
    end

    assign out_free = !result_valid_reg || !result_stall;
    assign emit     = (state_reg == ST_SCAN) && cur_occupied && out_free;
    assign advance  = (state_reg == ST_SCAN) && (!cur_occupied || out_free);
    assign scan_end = advance && (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign idx_wide = {3'b000, idx_reg};

    // Compute next slot contents: apply on pop, retire at end of scan
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            phase_next[i]   = phase_reg[i];
            contact_next[i] = contact_reg[i];
            x_next[i]       = x_reg[i];
            y_next[i]       = y_reg[i];
            if (pop && cmd.is_report)
            begin
                if (hit_found)
                begin
                    if (hit_idx == IDX_W'(i) &&
                        (cmd.kind == KIND_MOVE || cmd.kind == KIND_RELEASE))
                    begin
                        x_next[i]     = cmd.x;
                        y_next[i]     = cmd.y;
                        phase_next[i] = (cmd.kind == KIND_MOVE) ? PH_MOVING : PH_RELEASED;
                    end
                end
                else if (cmd.kind == KIND_PRESS && free_found && free_idx == IDX_W'(i))
                begin
                    phase_next[i]   = PH_PRESSED;
                    contact_next[i] = cmd.id;
                    x_next[i]       = cmd.x;
                    y_next[i]       = cmd.y;
                end
            end
            if (scan_end)
            begin
                if (phase_reg[i] == PH_RELEASED)
                begin
                    phase_next[i]   = PH_EMPTY;
                    contact_next[i] = '0;
                    x_next[i]       = '0;
                    y_next[i]       = '0;
                end
                else if (phase_reg[i] == PH_PRESSED)
                begin
                    phase_next[i] = PH_MOVING;
                end
            end
        end
    end

    // Hold slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                phase_reg[i]   <= PH_EMPTY;
                contact_reg[i] <= '0;
                x_reg[i]       <= '0;
                y_reg[i]       <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                phase_reg[i]   <= phase_next[i];
                contact_reg[i] <= contact_next[i];
                x_reg[i]       <= x_next[i];
                y_reg[i]       <= y_next[i];
            end
        end
    end

    // Sequence the scan and drive the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_SCAN;
                        idx_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (advance)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.slot_index <= idx_wide[2:0];
            result_reg.out_id     <= contact_reg[idx_reg];
            result_reg.out_x      <= x_reg[idx_reg];
            result_reg.out_y      <= y_reg[idx_reg];
            result_reg.event_kind <= cur_event;
            result_reg.last       <= !more_after;
        end
    end

endmodule

// ===== rtl/multitouch_contact_slot_tracker.sv =====
// ----------------------------------------------------------------------------
// multitouch_contact_slot_tracker
// Tracks finger contacts in slots and reports every occupied slot per item.
// ----------------------------------------------------------------------------
// Usage:
//   report channel (report_valid / report_stall / report): one item is a
//   touch report (opcode 0) or a frame tick (opcode 1). The front scales the
//   coordinates by the 8.8 factor and queues a command; report_stall rises
//   only while the two-entry command queue is full.
//   result channel (result_valid / result_stall / result): one item per
//   occupied slot in ascending slot order, last set on the final one. An item
//   that finds every slot empty produces nothing.
//   scale channel (scale_valid / scale_ready / scale_data): writes the
//   coordinate scale; ready is always high. Write only while idle.
// Timing: the slot engine pops a queued command only while idle, applies it
//   as it pops it, then scans the slots in ascending order; it takes no new
//   command until the scan ends. Each occupied slot loads the result register
//   as the scan reaches it, and empty slots are passed over. A stall on the
//   result side holds the scan on the current occupied slot.
// Reset: all slots empty, coordinates and ids zero, scale 1.0 (256).
// ----------------------------------------------------------------------------
module multitouch_contact_slot_tracker #(
    parameter int SLOT_COUNT = mtst_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_stall,
    input  mtst_pkg::report_t report,
    output logic              result_valid,
    input  logic              result_stall,
    output mtst_pkg::result_t result,
    input  logic              scale_valid,
    output logic              scale_ready,
    input  logic [15:0]       scale_data
);
    import mtst_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    cmd_t pop_cmd;
    logic queue_not_empty;

    // Accept and classify items
    mtst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .scale_valid  (scale_valid),
        .scale_ready  (scale_ready),
        .scale_data   (scale_data),
        .push         (push),
        .push_cmd     (push_cmd),
        .queue_full   (queue_full)
    );

    // Buffer commands between front and engine
    mtst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (queue_not_empty)
    );

    // Apply reports and emit slot results
    mtst_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_not_empty),
        .cmd          (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== dv/multitouch_contact_slot_tracker_test.sv =====
// ----------------------------------------------------------------------------
// multitouch_contact_slot_tracker_test
// Self-checking bench: a queued driver feeds touch reports and frame ticks,
// a slot-tracking predictor builds the expected per-slot reports, and a
// monitor checks every result field by field under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multitouch_contact_slot_tracker_test;

    import mtst_pkg::*;

    localparam int          NUM_SLOTS    = 8;
    localparam int          SETTLE_WAIT  = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          END_BUDGET   = 20000;
    localparam logic [1:0]  KIND_IGNORED = 2'd3;

    // Slot life cycle of the predictor
    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_PRESSED,
        SLOT_MOVING,
        SLOT_RELEASED
    } slot_phase_t;

    // Steps of the stimulus plan
    typedef enum logic [2:0] {
        STEP_ITEM,
        STEP_SCALE,
        STEP_SETTLE,
        STEP_HOLD,
        STEP_IDLE_ON,
        STEP_IDLE_OFF
    } step_t;

    typedef struct {
        step_t       kind;
        report_t     item;
        logic [15:0] value;
    } plan_step_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        report_valid = 1'b0;
    logic        report_stall;
    report_t     report       = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        scale_valid  = 1'b0;
    logic        scale_ready;
    logic [15:0] scale_data   = '0;

    // Stimulus plan and expected slot reports
    plan_step_t  touch_plan[$];
    result_t     expected_slot_reports[$];
    logic [15:0] live_ids[$];

    // Predictor state
    slot_phase_t slot_phase [NUM_SLOTS];
    logic [15:0] slot_id    [NUM_SLOTS];
    logic [15:0] slot_x     [NUM_SLOTS];
    logic [15:0] slot_y     [NUM_SLOTS];
    logic [15:0] slot_scale = SCALE_RESET;

    // Run bookkeeping
    logic idle_on   = 1'b1;
    logic hold_kick = 1'b0;
    int   gap_left, settle_count, stall_left, hold_left;
    int   items_taken, ticks_taken, results_seen, scale_writes, mismatches;

    multitouch_contact_slot_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .scale_valid  (scale_valid),
        .scale_ready  (scale_ready),
        .scale_data   (scale_data)
    );

    always #5 clk = ~clk;

    // Scale one raw coordinate by the current 8.8 factor, saturate at 16 bits
    function automatic logic [15:0] scaled_coord(input logic [11:0] raw);
        int unsigned prod;
        begin
            prod = (int'(raw) * int'(slot_scale)) >> 8;
            scaled_coord = (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
        end
    endfunction

    // Apply one accepted item to the slots and queue the reports it causes
    function automatic void track_contacts(input report_t rpt);
        logic [15:0] sx;
        logic [15:0] sy;
        int          hit;
        int          open_slot;
        int          final_slot;
        result_t     rep;
        begin
            if (rpt.opcode == OP_REPORT)
            begin
                sx  = scaled_coord(rpt.raw_x);
                sy  = scaled_coord(rpt.raw_y);
                hit = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (hit < 0 && slot_phase[i] != SLOT_EMPTY && slot_id[i] == rpt.contact_id)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    // known contact: move or release updates, repeated press holds
                    if (rpt.touch_kind == KIND_MOVE || rpt.touch_kind == KIND_RELEASE)
                    begin
                        slot_x[hit]     = sx;
                        slot_y[hit]     = sy;
                        slot_phase[hit] = (rpt.touch_kind == KIND_MOVE) ? SLOT_MOVING
                                                                        : SLOT_RELEASED;
                    end
                end
                else if (rpt.touch_kind == KIND_PRESS)
                begin
                    // new contact claims the lowest empty slot, if any
                    open_slot = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (open_slot < 0 && slot_phase[i] == SLOT_EMPTY)
                            open_slot = i;
                    end
                    if (open_slot >= 0)
                    begin
                        slot_phase[open_slot] = SLOT_PRESSED;
                        slot_id[open_slot]    = rpt.contact_id;
                        slot_x[open_slot]     = sx;
                        slot_y[open_slot]     = sy;
                    end
                end
            end

            // emit every occupied slot in order
            final_slot = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_phase[i] != SLOT_EMPTY)
                    final_slot = i;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_phase[i] != SLOT_EMPTY)
                begin
                    rep.slot_index = 3'(i);
                    rep.out_id     = slot_id[i];
                    rep.out_x      = slot_x[i];
                    rep.out_y      = slot_y[i];
                    case (slot_phase[i])
                        SLOT_PRESSED: rep.event_kind = EVT_PRESSED;
                        SLOT_MOVING:  rep.event_kind = EVT_MOVED;
                        default:      rep.event_kind = EVT_RELEASED;
                    endcase
                    rep.last = (i == final_slot);
                    expected_slot_reports = {expected_slot_reports, rep};
                end
            end

            // free released slots, advance fresh presses
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_phase[i] == SLOT_RELEASED)
                begin
                    slot_phase[i] = SLOT_EMPTY;
                    slot_id[i]    = '0;
                    slot_x[i]     = '0;
                    slot_y[i]     = '0;
                end
                else if (slot_phase[i] == SLOT_PRESSED)
                begin
                    slot_phase[i] = SLOT_MOVING;
                end
            end
        end
    endfunction

    task automatic compare_slot_report(input result_t want, input result_t got);
        begin
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.out_id !== want.out_id)
            begin
                $error("out_id: expected %h, got %h", want.out_id, got.out_id);
                mismatches++;
            end
            if (got.out_x !== want.out_x)
            begin
                $error("out_x: expected %h, got %h", want.out_x, got.out_x);
                mismatches++;
            end
            if (got.out_y !== want.out_y)
            begin
                $error("out_y: expected %h, got %h", want.out_y, got.out_y);
                mismatches++;
            end
            if (got.event_kind !== want.event_kind)
            begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    function automatic void queue_control(input step_t kind, input logic [15:0] value);
        plan_step_t s;
        begin
            s.kind  = kind;
            s.item  = '0;
            s.value = value;
            touch_plan = {touch_plan, s};
        end
    endfunction

    // Queue one item and keep the generator's list of live ids in step
    function automatic void queue_touch(input logic op, input logic [1:0] kind,
                                        input logic [11:0] x, input logic [11:0] y,
                                        input logic [15:0] id);
        plan_step_t s;
        int         pos;
        begin
            s.kind             = STEP_ITEM;
            s.value            = '0;
            s.item.opcode      = op;
            s.item.touch_kind  = kind;
            s.item.raw_x       = x;
            s.item.raw_y       = y;
            s.item.contact_id  = id;
            touch_plan = {touch_plan, s};
            if (op == OP_REPORT)
            begin
                pos = -1;
                for (int i = 0; i < live_ids.size(); i++)
                begin
                    if (live_ids[i] == id)
                        pos = i;
                end
                if (kind == KIND_RELEASE && pos >= 0)
                    live_ids.delete(pos);
                else if (kind == KIND_PRESS && pos < 0 && live_ids.size() < NUM_SLOTS)
                    live_ids = {live_ids, id};
            end
        end
    endfunction

    function automatic logic [11:0] pick_coord();
        begin
            if ($urandom_range(0, 9) == 0)
                pick_coord = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            else
                pick_coord = 12'($urandom_range(0, 4095));
        end
    endfunction

    // Mostly well-formed press / move / release sequences, some ticks and noise
    function automatic void queue_random_touches(input int count);
        int          r;
        logic [15:0] id;
        begin
            for (int n = 0; n < count; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    queue_touch(OP_TICK, 2'($urandom_range(0, 3)), 12'($urandom),
                                12'($urandom), 16'($urandom));
                end
                else if (r < 17 || live_ids.size() == 0 && r < 20)
                begin
                    queue_touch(OP_REPORT, 2'($urandom_range(1, 3)), pick_coord(),
                                pick_coord(), 16'($urandom));
                end
                else if (r < 20)
                begin
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                    queue_touch(OP_REPORT, KIND_PRESS, pick_coord(), pick_coord(), id);
                end
                else if (live_ids.size() == 0 || (live_ids.size() < NUM_SLOTS && r < 45))
                begin
                    queue_touch(OP_REPORT, KIND_PRESS, pick_coord(), pick_coord(),
                                16'($urandom));
                end
                else
                begin
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                    queue_touch(OP_REPORT, (r < 80) ? KIND_MOVE : KIND_RELEASE,
                                pick_coord(), pick_coord(), id);
                end
            end
        end
    endfunction

    // Driver: feed the plan, predict on every accepted item or scale write
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic        nxt_valid;
        report_t     nxt_report;
        logic        nxt_scale_valid;
        logic [15:0] nxt_scale;
        logic        nxt_kick;
        logic        nxt_idle;
        if (!rst_n)
        begin
            report_valid <= 1'b0;
            report       <= '0;
            scale_valid  <= 1'b0;
            scale_data   <= '0;
            hold_kick    <= 1'b0;
            idle_on      <= 1'b1;
            gap_left     = 0;
            settle_count = 0;
        end
        else
        begin
            nxt_valid       = report_valid;
            nxt_report      = report;
            nxt_scale_valid = scale_valid;
            nxt_scale       = scale_data;
            nxt_kick        = 1'b0;
            nxt_idle        = idle_on;

            if (report_valid && !report_stall)
            begin
                track_contacts(report);
                items_taken++;
                if (report.opcode == OP_TICK)
                    ticks_taken++;
                nxt_valid = 1'b0;
            end
            if (scale_valid && scale_ready)
            begin
                slot_scale = scale_data;
                scale_writes++;
                nxt_scale_valid = 1'b0;
            end

            // pick the next step once both channels are free
            if (!nxt_valid && !nxt_scale_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (touch_plan.size() > 0)
                begin
                    case (touch_plan[0].kind)
                        STEP_ITEM:
                        begin
                            if (idle_on && $urandom_range(0, 4) == 0)
                            begin
                                gap_left = $urandom_range(0, 7);
                            end
                            else
                            begin
                                nxt_valid  = 1'b1;
                                nxt_report = touch_plan[0].item;
                                void'(touch_plan.pop_front());
                            end
                        end
                        STEP_SCALE:
                        begin
                            nxt_scale_valid = 1'b1;
                            nxt_scale       = touch_plan[0].value;
                            void'(touch_plan.pop_front());
                        end
                        STEP_SETTLE:
                        begin
                            // wait for every result, then let the engine go quiet
                            if (expected_slot_reports.size() != 0)
                            begin
                                settle_count = 0;
                            end
                            else if (settle_count < SETTLE_WAIT)
                            begin
                                settle_count++;
                            end
                            else
                            begin
                                settle_count = 0;
                                void'(touch_plan.pop_front());
                            end
                        end
                        STEP_HOLD:
                        begin
                            nxt_kick = 1'b1;
                            void'(touch_plan.pop_front());
                        end
                        STEP_IDLE_ON:
                        begin
                            nxt_idle = 1'b1;
                            void'(touch_plan.pop_front());
                        end
                        default:
                        begin
                            nxt_idle = 1'b0;
                            void'(touch_plan.pop_front());
                        end
                    endcase
                end
            end

            report_valid <= nxt_valid;
            report       <= nxt_report;
            scale_valid  <= nxt_scale_valid;
            scale_data   <= nxt_scale;
            hold_kick    <= nxt_kick;
            idle_on      <= nxt_idle;
        end
    end

    // Monitor: check each accepted result, drive random and long stalls
    always @(posedge clk or negedge rst_n)
    begin : observe
        logic nxt_stall;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_slot_reports.size() == 0)
                begin
                    $error("unexpected result: slot %0d id %h", result.slot_index,
                           result.out_id);
                    mismatches++;
                end
                else
                begin
                    compare_slot_report(expected_slot_reports.pop_front(), result);
                end
                results_seen++;
            end

            if (hold_kick)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                nxt_stall  = 1'b1;
            end
            else
            begin
                nxt_stall = 1'b0;
            end
            result_stall <= nxt_stall;
        end
    end

    // Stimulus plan, reset and end of run
    initial
    begin : run
        int waited;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_phase[i] = SLOT_EMPTY;
            slot_id[i]    = '0;
            slot_x[i]     = '0;
            slot_y[i]     = '0;
        end

        // directed: empty tick, drops, extremes, repeats, full slots
        queue_touch(OP_TICK, KIND_IGNORED, 12'hFFF, 12'hFFF, 16'hFFFF);
        queue_touch(OP_REPORT, KIND_MOVE, 12'd10, 12'd20, 16'd5);
        queue_touch(OP_REPORT, KIND_PRESS, 12'h000, 12'h000, 16'h0000);
        queue_touch(OP_REPORT, KIND_PRESS, 12'hFFF, 12'hFFF, 16'hFFFF);
        queue_touch(OP_REPORT, KIND_PRESS, 12'd100, 12'd200, 16'h0000);
        queue_touch(OP_REPORT, KIND_MOVE, 12'd1, 12'd2, 16'hFFFF);
        queue_touch(OP_REPORT, KIND_IGNORED, 12'd33, 12'd44, 16'h0000);
        queue_touch(OP_REPORT, KIND_RELEASE, 12'hFFF, 12'h000, 16'h0000);
        queue_touch(OP_TICK, KIND_PRESS, 12'h000, 12'h000, 16'h0000);
        for (int i = 0; i < NUM_SLOTS - 1; i++)
            queue_touch(OP_REPORT, KIND_PRESS, 12'(i * 500), 12'(4095 - i * 500), 16'(100 + i));
        queue_touch(OP_REPORT, KIND_PRESS, 12'd7, 12'd8, 16'd200);
        queue_touch(OP_REPORT, KIND_RELEASE, 12'd9, 12'd9, 16'd300);
        queue_touch(OP_REPORT, KIND_RELEASE, 12'd7, 12'd7, 16'hFFFF);
        queue_touch(OP_TICK, KIND_MOVE, 12'h555, 12'hAAA, 16'h5A5A);

        // random phases across scale settings, extremes first
        queue_control(STEP_SETTLE, '0);
        queue_control(STEP_SCALE, 16'hFFFF);
        queue_random_touches(80);
        queue_control(STEP_SETTLE, '0);
        queue_control(STEP_SCALE, 16'h0000);
        queue_control(STEP_IDLE_OFF, '0);
        queue_control(STEP_HOLD, '0);
        queue_random_touches(40);
        queue_control(STEP_IDLE_ON, '0);
        queue_random_touches(40);
        queue_control(STEP_SETTLE, '0);
        queue_control(STEP_SCALE, 16'($urandom));
        queue_random_touches(80);
        queue_control(STEP_SETTLE, '0);
        queue_control(STEP_SCALE, 16'($urandom_range(1, 1023)));
        queue_random_touches(80);
        queue_control(STEP_IDLE_OFF, '0);
        queue_control(STEP_SETTLE, '0);
        queue_control(STEP_SCALE, SCALE_RESET);
        queue_random_touches(90);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        waited = 0;
        while ((touch_plan.size() != 0 || report_valid || scale_valid
                || expected_slot_reports.size() != 0) && waited < END_BUDGET)
        begin
            @(posedge clk);
            if (touch_plan.size() == 0)
                waited++;
        end
        repeat (SETTLE_WAIT) @(posedge clk);
        if (expected_slot_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_slot_reports.size());
            mismatches++;
        end

        $display("covered %0d items (%0d frame ticks), %0d slot reports checked,",
                 items_taken, ticks_taken, results_seen);
        $display("%0d coordinate scale settings including both extremes", scale_writes);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mtst_pkg.sv
rtl/mtst_front.sv
rtl/mtst_queue.sv
rtl/mtst_back.sv
rtl/multitouch_contact_slot_tracker.sv
dv/multitouch_contact_slot_tracker_test.sv
